>>> src/e2q_pkg.sv
package e2q_pkg;

    localparam int DEF_ANGLE_BITS     = 16;
    localparam int DEF_COMPONENT_BITS = 16;
    localparam int DEF_CORDIC_STEPS   = 14;
    localparam int MAX_CORDIC_STEPS   = 30;

    localparam int IFRAC = 30;
    localparam logic [63:0] PI_Q62 = 64'hC90F_DAA2_2168_C235;

    localparam int LANES     = 3;
    localparam int LANE_PITCH = 0;
    localparam int LANE_YAW   = 1;
    localparam int LANE_ROLL  = 2;

    typedef logic signed [31:0] q30_t;

    typedef struct packed {
        q30_t x;
        q30_t y;
        q30_t z;
    } lane_t;

    typedef lane_t [LANES-1:0] cordic_word_t;
    typedef q30_t [3:0] term4_t;

    typedef enum logic [2:0] {
        ORDER_XYZ = 3'd0,
        ORDER_YXZ = 3'd1,
        ORDER_ZXY = 3'd2,
        ORDER_ZYX = 3'd3,
        ORDER_YZX = 3'd4
    } order_t;

    localparam logic [31:0] ATAN_Q30 [MAX_CORDIC_STEPS] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128,
        32'd64,        32'd32,        32'd16,        32'd8,
        32'd4,         32'd2
    };

    function automatic logic [63:0] pi_at(input int frac);
        int shift;
        shift = 62 - frac;
        return (PI_Q62 + (64'd1 << (shift - 1))) >> shift;
    endfunction

    function automatic logic [63:0] gain_square(input int steps);
        logic [63:0] p;
        p = 64'd1 << 60;
        for (int i = 0; i < MAX_CORDIC_STEPS; i++)
        begin
            if (i < steps)
            begin
                p = p + (p >> (2 * i));
            end
        end
        return p;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] value);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        n = value;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

endpackage

>>> src/e2q_if.sv
interface e2q_angle_if
    import e2q_pkg::*;
#(
    parameter int ANGLE_BITS = DEF_ANGLE_BITS
);
    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] yaw_angle;
    logic signed [ANGLE_BITS-1:0] roll_angle;

    modport source (output valid, output pitch_angle, output yaw_angle, output roll_angle,
                    input ready);
    modport sink   (input valid, input pitch_angle, input yaw_angle, input roll_angle,
                    output ready);
endinterface

interface e2q_quat_if
    import e2q_pkg::*;
#(
    parameter int COMPONENT_BITS = DEF_COMPONENT_BITS
);
    logic                             valid;
    logic                             ready;
    logic signed [COMPONENT_BITS-1:0] quat_w;
    logic signed [COMPONENT_BITS-1:0] quat_x;
    logic signed [COMPONENT_BITS-1:0] quat_y;
    logic signed [COMPONENT_BITS-1:0] quat_z;

    modport source (output valid, output quat_w, output quat_x, output quat_y, output quat_z,
                    input ready);
    modport sink   (input valid, input quat_w, input quat_x, input quat_y, input quat_z,
                    output ready);
endinterface

interface e2q_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] rotation_order;

    modport source (output valid, output rotation_order, input ready);
    modport sink   (input valid, input rotation_order, output ready);
endinterface

>>> src/e2q_prep.sv
module e2q_prep
    import e2q_pkg::*;
#(
    parameter int ANGLE_BITS   = DEF_ANGLE_BITS,
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [ANGLE_BITS-1:0] pitch_angle,
    input  logic signed [ANGLE_BITS-1:0] yaw_angle,
    input  logic signed [ANGLE_BITS-1:0] roll_angle,
    output logic                         out_valid,
    input  logic                         out_ready,
    output cordic_word_t                 out_word
);

    localparam int HALF_SHIFT = 32 - ANGLE_BITS;
    localparam logic signed [ANGLE_BITS-1:0] LIMIT = ANGLE_BITS'(pi_at(ANGLE_BITS - 3));
    localparam logic [63:0] GAIN_ROOT = isqrt64(gain_square(CORDIC_STEPS));
    localparam logic [63:0] GAIN_Q30 = ((64'd1 << (2 * IFRAC)) + (GAIN_ROOT >> 1)) / GAIN_ROOT;
    localparam q30_t GAIN = q30_t'(GAIN_Q30);

    logic signed [ANGLE_BITS-1:0] angle_w [LANES];
    logic signed [ANGLE_BITS-1:0] clamp_w [LANES];
    cordic_word_t                 word_next;
    cordic_word_t                 word_reg;
    logic                         valid_reg;

    assign angle_w[LANE_PITCH] = pitch_angle;
    assign angle_w[LANE_YAW]   = yaw_angle;
    assign angle_w[LANE_ROLL]  = roll_angle;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (angle_w[l] > LIMIT)
            begin
                clamp_w[l] = LIMIT;
            end
            else if (angle_w[l] < -LIMIT)
            begin
                clamp_w[l] = -LIMIT;
            end
            else
            begin
                clamp_w[l] = angle_w[l];
            end
            word_next[l].x = GAIN;
            word_next[l].y = '0;
            word_next[l].z = q30_t'(clamp_w[l]) <<< HALF_SHIFT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            word_reg <= word_next;
        end
    end

endmodule

>>> src/e2q_cordic_stage.sv
module e2q_cordic_stage
    import e2q_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  cordic_word_t in_word,
    output logic         out_valid,
    input  logic         out_ready,
    output cordic_word_t out_word
);

    localparam q30_t STEP_ANGLE = q30_t'(ATAN_Q30[STEP]);

    cordic_word_t word_next;
    cordic_word_t word_reg;
    logic         valid_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (in_word[l].z >= 0)
            begin
                word_next[l].x = in_word[l].x - (in_word[l].y >>> STEP);
                word_next[l].y = in_word[l].y + (in_word[l].x >>> STEP);
                word_next[l].z = in_word[l].z - STEP_ANGLE;
            end
            else
            begin
                word_next[l].x = in_word[l].x + (in_word[l].y >>> STEP);
                word_next[l].y = in_word[l].y - (in_word[l].x >>> STEP);
                word_next[l].z = in_word[l].z + STEP_ANGLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            word_reg <= word_next;
        end
    end

endmodule

>>> src/e2q_mult.sv
module e2q_mult
    import e2q_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  cordic_word_t in_word,
    output logic         out_valid,
    input  logic         out_ready,
    output term4_t       a_term,
    output term4_t       b_term
);

    function automatic q30_t q30_mul(input q30_t lhs, input q30_t rhs);
        logic signed [63:0] prod;
        prod = 64'(lhs) * 64'(rhs);
        return q30_t'((prod + (64'sd1 <<< (IFRAC - 1))) >>> IFRAC);
    endfunction

    logic   pair_valid_reg;
    logic   pair_ready;
    term4_t pair_next;
    term4_t pair_reg;
    q30_t   sr_reg;
    q30_t   cr_reg;

    logic   term_valid_reg;
    logic   term_ready;
    term4_t a_next;
    term4_t b_next;
    term4_t a_reg;
    term4_t b_reg;

    assign pair_ready = !pair_valid_reg || term_ready;
    assign term_ready = !term_valid_reg || out_ready;
    assign in_ready   = pair_ready;
    assign out_valid  = term_valid_reg;
    assign a_term     = a_reg;
    assign b_term     = b_reg;

    // sp*cy, cp*sy, cp*cy, sp*sy
    always_comb
    begin
        pair_next[0] = q30_mul(in_word[LANE_PITCH].y, in_word[LANE_YAW].x);
        pair_next[1] = q30_mul(in_word[LANE_PITCH].x, in_word[LANE_YAW].y);
        pair_next[2] = q30_mul(in_word[LANE_PITCH].x, in_word[LANE_YAW].x);
        pair_next[3] = q30_mul(in_word[LANE_PITCH].y, in_word[LANE_YAW].y);
    end

    always_comb
    begin
        a_next[0] = q30_mul(pair_reg[0], cr_reg);
        b_next[0] = q30_mul(pair_reg[1], sr_reg);
        a_next[1] = q30_mul(pair_reg[1], cr_reg);
        b_next[1] = q30_mul(pair_reg[0], sr_reg);
        a_next[2] = q30_mul(pair_reg[2], sr_reg);
        b_next[2] = q30_mul(pair_reg[3], cr_reg);
        a_next[3] = q30_mul(pair_reg[2], cr_reg);
        b_next[3] = q30_mul(pair_reg[3], sr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_valid_reg <= 1'b0;
            term_valid_reg <= 1'b0;
        end
        else
        begin
            if (pair_ready)
            begin
                pair_valid_reg <= in_valid;
            end
            if (term_ready)
            begin
                term_valid_reg <= pair_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pair_ready)
        begin
            pair_reg <= pair_next;
            sr_reg   <= in_word[LANE_ROLL].y;
            cr_reg   <= in_word[LANE_ROLL].x;
        end
        if (term_ready)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

endmodule

>>> src/e2q_out.sv
module e2q_out
    import e2q_pkg::*;
#(
    parameter int COMPONENT_BITS = DEF_COMPONENT_BITS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  term4_t                           a_term,
    input  term4_t                           b_term,
    input  logic [2:0]                       rotation_order,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [COMPONENT_BITS-1:0] quat_w,
    output logic signed [COMPONENT_BITS-1:0] quat_x,
    output logic signed [COMPONENT_BITS-1:0] quat_y,
    output logic signed [COMPONENT_BITS-1:0] quat_z
);

    localparam int CFRAC = COMPONENT_BITS - 2;
    localparam int SHIFT = IFRAC - CFRAC;
    localparam logic signed [33:0] ROUND_BIAS = 34'sd1 <<< SHIFT >>> 1;
    localparam logic signed [33:0] ONE = 34'sd1 <<< CFRAC;

    logic [3:0]                       add_mask;
    logic signed [32:0]               sum_w [4];
    logic signed [33:0]               rnd_w [4];
    logic signed [33:0]               sat_w [4];
    logic signed [COMPONENT_BITS-1:0] comp_reg [4];
    logic                             valid_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign quat_x    = comp_reg[0];
    assign quat_y    = comp_reg[1];
    assign quat_z    = comp_reg[2];
    assign quat_w    = comp_reg[3];

    // bit j set: add b term, order w z y x from high to low
    always_comb
    begin
        unique case (order_t'(rotation_order))
            ORDER_YXZ: add_mask = 4'b1001;
            ORDER_ZXY: add_mask = 4'b0110;
            ORDER_ZYX: add_mask = 4'b1010;
            ORDER_YZX: add_mask = 4'b0011;
            default:   add_mask = 4'b0101;
        endcase
    end

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            if (add_mask[j])
            begin
                sum_w[j] = 33'(signed'(a_term[j])) + 33'(signed'(b_term[j]));
            end
            else
            begin
                sum_w[j] = 33'(signed'(a_term[j])) - 33'(signed'(b_term[j]));
            end
            rnd_w[j] = (34'(sum_w[j]) + ROUND_BIAS) >>> SHIFT;
            if (rnd_w[j] > ONE)
            begin
                sat_w[j] = ONE;
            end
            else if (rnd_w[j] < -ONE)
            begin
                sat_w[j] = -ONE;
            end
            else
            begin
                sat_w[j] = rnd_w[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            for (int j = 0; j < 4; j++)
            begin
                comp_reg[j] <= COMPONENT_BITS'(sat_w[j]);
            end
        end
    end

endmodule

>>> src/euler_to_quaternion.sv
// Euler angles (pitch, yaw, roll; Q2.13 radians, clamped to plus or minus pi) to a unit
// quaternion (Q1.14, saturated to plus or minus one). Fully pipelined: one angle triple per
// cycle. It has one stage for the half-angle clamp, one per CORDIC micro-rotation, two
// multiplier stages and one sign-combine/round output stage. The pipeline
// holds on output backpressure and fills bubbles. rotation_order selects XYZ, YXZ, ZXY, ZYX or
// YZX (codes 0 to 4, other codes act as XYZ); write it only while no transaction is in flight.
module euler_to_quaternion
    import e2q_pkg::*;
#(
    parameter int ANGLE_BITS     = DEF_ANGLE_BITS,
    parameter int COMPONENT_BITS = DEF_COMPONENT_BITS,
    parameter int CORDIC_STEPS   = DEF_CORDIC_STEPS
)
(
    input  logic          clk,
    input  logic          rst_n,
    e2q_angle_if.sink     angles,
    e2q_quat_if.source    quat,
    e2q_cfg_if.sink       cfg
);

    logic [2:0] rotation_order_reg;

    wire  [CORDIC_STEPS:0] chain_valid;
    wire  [CORDIC_STEPS:0] chain_ready;
    wire  cordic_word_t    chain_word [CORDIC_STEPS+1];

    logic   term_valid;
    logic   term_ready;
    term4_t a_term;
    term4_t b_term;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_order_reg <= ORDER_XYZ;
        end
        else if (cfg.valid)
        begin
            rotation_order_reg <= cfg.rotation_order;
        end
    end

    e2q_prep #(
        .ANGLE_BITS   (ANGLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (angles.valid),
        .in_ready    (angles.ready),
        .pitch_angle (angles.pitch_angle),
        .yaw_angle   (angles.yaw_angle),
        .roll_angle  (angles.roll_angle),
        .out_valid   (chain_valid[0]),
        .out_ready   (chain_ready[0]),
        .out_word    (chain_word[0])
    );

    for (genvar s = 0; s < CORDIC_STEPS; s++)
    begin : g_cordic
        e2q_cordic_stage #(
            .STEP (s)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[s]),
            .in_ready  (chain_ready[s]),
            .in_word   (chain_word[s]),
            .out_valid (chain_valid[s+1]),
            .out_ready (chain_ready[s+1]),
            .out_word  (chain_word[s+1])
        );
    end

    e2q_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[CORDIC_STEPS]),
        .in_ready  (chain_ready[CORDIC_STEPS]),
        .in_word   (chain_word[CORDIC_STEPS]),
        .out_valid (term_valid),
        .out_ready (term_ready),
        .a_term    (a_term),
        .b_term    (b_term)
    );

    e2q_out #(
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (term_valid),
        .in_ready       (term_ready),
        .a_term         (a_term),
        .b_term         (b_term),
        .rotation_order (rotation_order_reg),
        .out_valid      (quat.valid),
        .out_ready      (quat.ready),
        .quat_w         (quat.quat_w),
        .quat_x         (quat.quat_x),
        .quat_y         (quat.quat_y),
        .quat_z         (quat.quat_z)
    );

endmodule

>>> bench/tb_euler_to_quaternion.sv
`timescale 1ns / 100ps

module tb_euler_to_quaternion;
    import e2q_pkg::*;

    localparam int AW    = DEF_ANGLE_BITS;
    localparam int CW    = DEF_COMPONENT_BITS;
    localparam int STEPS = DEF_CORDIC_STEPS;

    localparam int FRAC_INT  = 30;
    localparam int FRAC_ANG  = AW - 3;
    localparam int FRAC_COMP = CW - 2;
    localparam logic [63:0] PI_FIX62 = 64'hC90F_DAA2_2168_C235;

    localparam logic [2:0] ORDER_SPARE_LO = 3'd5;
    localparam logic [2:0] ORDER_SPARE_HI = 3'd7;

    localparam int NUM_PHASES     = 7;
    localparam int PHASE_ITEMS    = 86;
    localparam int PRESSURE_PHASE = 2;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 2 * (STEPS + 4);
    localparam int WATCHDOG_LIMIT = 2000;

    typedef logic signed [AW-1:0] angle_t;

    typedef struct packed {
        logic signed [CW-1:0] w;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } quat_t;

    class quat_scoreboard;
        quat_t      expected_quats[$];
        logic [2:0] order_reg;
        longint     gain_q30;
        int         mismatches;

        function new();
            order_reg  = ORDER_XYZ;
            mismatches = 0;
            gain_q30   = cordic_gain();
        endfunction

        function logic [63:0] int_sqrt(logic [63:0] value);
            logic [63:0] n;
            logic [63:0] r;
            logic [63:0] b;
            n = value;
            r = 64'd0;
            b = 64'd1 << 62;
            while (b > n)
                b = b >> 2;
            while (b != 0)
            begin
                if (n >= r + b)
                begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function longint cordic_gain();
            logic [63:0] p;
            logic [63:0] s;
            p = 64'd1 << 60;
            for (int i = 0; i < STEPS; i++)
                p = p + (p >> (2 * i));
            s = int_sqrt(p);
            return longint'(((64'd1 << 60) + (s >> 1)) / s);
        endfunction

        function longint arctan_step(int i);
            longint sum;
            longint term;
            sum = 0;
            if (i == 0)
                return longint'((PI_FIX62 + (64'd1 << 33)) >> 34);
            for (int k = 0; i * (2 * k + 1) <= 62; k++)
            begin
                term = longint'(64'd1 << (62 - i * (2 * k + 1))) / longint'(2 * k + 1);
                if (k % 2 == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            return (sum + (longint'(1) << 31)) >>> 32;
        endfunction

        function longint mul_q30(longint a, longint b);
            return (a * b + (longint'(1) << (FRAC_INT - 1))) >>> FRAC_INT;
        endfunction

        function longint angle_half_q30(angle_t raw);
            longint v;
            longint lim;
            v   = longint'(raw);
            lim = longint'((PI_FIX62 + (64'd1 << (62 - FRAC_ANG - 1))) >> (62 - FRAC_ANG));
            if (v > lim)
                v = lim;
            if (v < -lim)
                v = -lim;
            return v * (longint'(1) << (FRAC_INT - FRAC_ANG - 1));
        endfunction

        function void half_sincos(input longint ang, output longint s, output longint c);
            longint x;
            longint y;
            longint z;
            longint dx;
            longint dy;
            longint t;
            x = gain_q30;
            y = 0;
            z = ang;
            for (int i = 0; i < STEPS; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                t  = arctan_step(i);
                if (z >= 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - t;
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + t;
                end
            end
            s = y;
            c = x;
        endfunction

        function logic signed [CW-1:0] to_component(longint v);
            longint r;
            longint one;
            one = longint'(1) << FRAC_COMP;
            r   = (v + (longint'(1) << (FRAC_INT - FRAC_COMP - 1))) >>> (FRAC_INT - FRAC_COMP);
            if (r > one)
                r = one;
            if (r < -one)
                r = -one;
            return r[CW-1:0];
        endfunction

        // bit 0 x, bit 1 y, bit 2 z, bit 3 w; set means the b term is added
        function logic [3:0] add_mask(logic [2:0] ord);
            case (ord)
                ORDER_YXZ: return 4'b1001;
                ORDER_ZXY: return 4'b0110;
                ORDER_ZYX: return 4'b1010;
                ORDER_YZX: return 4'b0011;
                default:   return 4'b0101;
            endcase
        endfunction

        function quat_t predict_quat(angle_t pitch, angle_t yaw, angle_t roll);
            longint sp, cp, sy, cy, sr, cr;
            longint a[4];
            longint b[4];
            longint q[4];
            logic [3:0] mask;
            quat_t res;
            half_sincos(angle_half_q30(pitch), sp, cp);
            half_sincos(angle_half_q30(yaw), sy, cy);
            half_sincos(angle_half_q30(roll), sr, cr);
            a[0] = mul_q30(mul_q30(sp, cy), cr);
            b[0] = mul_q30(mul_q30(cp, sy), sr);
            a[1] = mul_q30(mul_q30(cp, sy), cr);
            b[1] = mul_q30(mul_q30(sp, cy), sr);
            a[2] = mul_q30(mul_q30(cp, cy), sr);
            b[2] = mul_q30(mul_q30(sp, sy), cr);
            a[3] = mul_q30(mul_q30(cp, cy), cr);
            b[3] = mul_q30(mul_q30(sp, sy), sr);
            mask = add_mask(order_reg);
            for (int j = 0; j < 4; j++)
                q[j] = mask[j] ? a[j] + b[j] : a[j] - b[j];
            res.w = to_component(q[3]);
            res.x = to_component(q[0]);
            res.y = to_component(q[1]);
            res.z = to_component(q[2]);
            return res;
        endfunction

        function void note_angles(angle_t pitch, angle_t yaw, angle_t roll);
            expected_quats.push_back(predict_quat(pitch, yaw, roll));
        endfunction

        function void check_quat(quat_t got);
            quat_t want;
            if (expected_quats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected quaternion w=%0d x=%0d y=%0d z=%0d",
                             got.w, got.x, got.y, got.z);
                return;
            end
            want = expected_quats.pop_front();
            if (got.w !== want.w || got.x !== want.x || got.y !== want.y || got.z !== want.z)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $write("quaternion mismatch: expected w=%0d x=%0d y=%0d z=%0d, ",
                           want.w, want.x, want.y, want.z);
                    $display("got w=%0d x=%0d y=%0d z=%0d", got.w, got.x, got.y, got.z);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic send_idle;
    logic recv_idle;
    logic hold_req;
    int   idle_cycles;

    quat_scoreboard board;

    e2q_angle_if #(.ANGLE_BITS(AW))     angles_if();
    e2q_quat_if  #(.COMPONENT_BITS(CW)) quat_if();
    e2q_cfg_if                          cfg_if();

    euler_to_quaternion #(
        .ANGLE_BITS     (AW),
        .COMPONENT_BITS (CW),
        .CORDIC_STEPS   (STEPS)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .angles (angles_if),
        .quat   (quat_if),
        .cfg    (cfg_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic angle_t rand_angle();
        int sel;
        sel = $urandom_range(99);
        if (sel < 6)
            return angle_t'($urandom);
        if (sel < 9)
            return angle_t'(25736);
        if (sel < 12)
            return angle_t'(-25736);
        return angle_t'(int'($urandom_range(51472)) - 25736);
    endfunction

    task automatic send_angles(angle_t pitch, angle_t yaw, angle_t roll);
        int gap;
        gap = send_idle ? $urandom_range(13) : 0;
        if (gap != 0)
        begin
            angles_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        angles_if.valid       <= 1'b1;
        angles_if.pitch_angle <= pitch;
        angles_if.yaw_angle   <= yaw;
        angles_if.roll_angle  <= roll;
        do
            @(posedge clk);
        while (!angles_if.ready);
        board.note_angles(pitch, yaw, roll);
        @(negedge clk);
    endtask

    task automatic write_order(logic [2:0] ord);
        cfg_if.valid          <= 1'b1;
        cfg_if.rotation_order <= ord;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        board.order_reg = ord;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic drain();
        angles_if.valid <= 1'b0;
        while (board.expected_quats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_directed();
        send_angles(0, 0, 0);
        send_angles(25736, 25736, 25736);
        send_angles(-25736, -25736, -25736);
        send_angles(32767, -32768, 0);
        send_angles(-32768, 32767, 25737);
        send_angles(25736, -25736, 0);
        send_angles(12868, 0, 0);
        send_angles(0, 12868, 0);
        send_angles(0, 0, 12868);
        send_angles(-1, 1, -1);
        send_angles(1, -1, 1);
        send_angles(6434, -19302, 21447);
    endtask

    // receiver: random ready gaps, plus one long hold-off on request
    initial
    begin
        quat_t got;
        int    gap;
        quat_if.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                quat_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            gap = recv_idle ? $urandom_range(13) : 0;
            if (gap != 0)
            begin
                quat_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            quat_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!quat_if.valid);
            got.w = quat_if.quat_w;
            got.x = quat_if.quat_x;
            got.y = quat_if.quat_y;
            got.z = quat_if.quat_z;
            board.check_quat(got);
            @(negedge clk);
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((angles_if.valid && angles_if.ready) || (quat_if.valid && quat_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_euler_to_quaternion NOT OK");
        $finish;
    end

    initial
    begin
        logic [2:0] orders [NUM_PHASES];
        orders = '{ORDER_YZX, ORDER_XYZ, ORDER_YXZ, ORDER_SPARE_HI, ORDER_ZXY, ORDER_ZYX,
                   ORDER_SPARE_LO};
        board                 = new();
        rst_n                 = 1'b0;
        send_idle             = 1'b0;
        recv_idle             = 1'b0;
        hold_req              = 1'b0;
        angles_if.valid       = 1'b0;
        angles_if.pitch_angle = '0;
        angles_if.yaw_angle   = '0;
        angles_if.roll_angle  = '0;
        cfg_if.valid          = 1'b0;
        cfg_if.rotation_order = ORDER_XYZ;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_directed();
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_order(orders[ph]);
            send_idle = (ph % 3) != 0;
            recv_idle = (ph % 4) != 1;
            if (ph == PRESSURE_PHASE)
            begin
                send_idle = 1'b0;
                hold_req  = 1'b1;
            end
            if (orders[ph] == ORDER_SPARE_HI)
                send_directed();
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_angles(rand_angle(), rand_angle(), rand_angle());
            drain();
        end

        if (board.mismatches == 0 && board.expected_quats.size() == 0)
            $display("tb_euler_to_quaternion OK");
        else
            $display("tb_euler_to_quaternion NOT OK");
        $finish;
    end

endmodule
